// ----- design/tlvps_pkg.sv -----
// ---------------------------------------------------------------------------
// tlvps_pkg
// shared constants, command and status codes, and sequencer states for the
// tag-length-value parameter store
// ---------------------------------------------------------------------------
package tlvps_pkg;

  localparam int BufferBytesDef = 256;
  localparam int EntryHead      = 2;
  localparam int MaxValue       = 4;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPEND,
    S_WALK_TAG,
    S_WALK_LEN,
    S_VAL,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

endpackage

// ----- design/tlvps_ram.sv -----
// ---------------------------------------------------------------------------
// tlvps_ram
// generic single-port synchronous ram, one write or one read per cycle,
// registered read data
// ---------------------------------------------------------------------------
module tlvps_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- design/tlv_parameter_store_core.sv -----
// ---------------------------------------------------------------------------
// tlv_parameter_store_core
// tag-length-value byte buffer with append, remove, find and clear commands
// ---------------------------------------------------------------------------
// one beat in flight; clear goes straight to the result, append writes tag,
// length and value, one byte write per cycle, unless it is rejected as full
// find and remove walk the entries, reading each tag and length, then read
// the value one byte per cycle; remove then moves later bytes down, a read
// and a write per byte; the single ram port sets this sequencing; in_tready
// returns the cycle after the result beat is taken
// reset clears fill count, signalling code and control; buffer bytes are not
// cleared and no clearing pass runs
module tlv_parameter_store_core
  import tlvps_pkg::*;
#(
  parameter int BufferBytes = BufferBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[1:0], tag[9:2], value_size[12:10], value_data[44:13],
  // signalling_code[52:45], zero fill to 56
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], entry_position[9:2], entry_length[17:10],
  // entry_value[49:18], fill_bytes[57:50], signalling_now[65:58], zero to 72
  output logic [71:0] out_tdata
);

  localparam int AW = $clog2(BufferBytes);
  localparam int CW = AW + 1;

  state_t state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [7:0] sig_r, sig_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic [7:0] tag_r, tag_nxt;
  logic [2:0] size_r, size_nxt;
  logic [31:0] data_r, data_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;   // walk pointer / entry start
  logic [CW-1:0] idx_r, idx_nxt;   // byte index within step
  logic [7:0] len_r, len_nxt;
  logic [31:0] val_r, val_nxt;
  logic [CW-1:0] dst_r, dst_nxt;
  logic [CW-1:0] newfill_r, newfill_nxt;
  logic pend_r, pend_nxt;          // a read or an append step was issued last cycle
  logic [1:0] ost_r, ost_nxt;
  logic ovalid_r, ovalid_nxt;

  logic we;
  logic [CW-1:0] addr;
  logic [7:0] wdata, rdata;
  logic [CW-1:0] span;
  logic [CW+1:0] need;

  tlvps_ram #(.Width(8), .Depth(BufferBytes)) u_ram (
    .clk(clk), .we(we), .addr(addr[AW-1:0]), .wdata(wdata), .rdata(rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'd0, sig_r, 8'(fill_r), val_r, len_r, 8'(ptr_r), ost_r};
  assign span = CW'(len_r) + CW'(EntryHead);

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= '0;
      sig_r    <= '0;
      ovalid_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      sig_r    <= sig_nxt;
      ovalid_r <= ovalid_nxt;
      pend_r   <= pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; tag_r <= tag_nxt; size_r <= size_nxt; data_r <= data_nxt;
    ptr_r <= ptr_nxt; idx_r <= idx_nxt; len_r <= len_nxt; val_r <= val_nxt;
    dst_r <= dst_nxt; newfill_r <= newfill_nxt; ost_r <= ost_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r; fill_nxt = fill_r; sig_nxt = sig_r;
    cmd_nxt = cmd_r; tag_nxt = tag_r; size_nxt = size_r; data_nxt = data_r;
    ptr_nxt = ptr_r; idx_nxt = idx_r; len_nxt = len_r; val_nxt = val_r;
    dst_nxt = dst_r; newfill_nxt = newfill_r; ost_nxt = ost_r;
    ovalid_nxt = ovalid_r; pend_nxt = 1'b0;
    we = 1'b0; addr = ptr_r; wdata = 8'd0;
    need = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt  = cmd_t'(in_tdata[1:0]);
          tag_nxt  = in_tdata[9:2];
          size_nxt = (in_tdata[12:10] > 3'(MaxValue)) ? 3'(MaxValue) : in_tdata[12:10];
          data_nxt = in_tdata[44:13];
          ost_nxt = ST_OK; ptr_nxt = '0; len_nxt = '0; val_nxt = '0; idx_nxt = '0;
          case (cmd_t'(in_tdata[1:0]))
            CMD_CLEAR: begin
              fill_nxt = '0;
              sig_nxt = in_tdata[52:45];
              state_nxt = S_DONE;
            end
            CMD_APPEND: state_nxt = S_APPEND;
            default:    state_nxt = S_WALK_TAG;
          endcase
        end
      end
      S_APPEND: begin
        // first cycle fixes the result and rejects when full, then one byte per cycle
        if (idx_r == '0 && !pend_r) begin
          ptr_nxt = fill_r;
          len_nxt = {5'd0, size_r};
          case (size_r)
            3'd0: val_nxt = 32'd0;
            3'd1: val_nxt = {24'd0, data_r[7:0]};
            3'd2: val_nxt = {16'd0, data_r[15:0]};
            3'd3: val_nxt = {8'd0, data_r[23:0]};
            default: val_nxt = data_r;
          endcase
          need = (CW+2)'(fill_r) + (CW+2)'(size_r) + (CW+2)'(EntryHead);
          if (need >= (CW+2)'(BufferBytes)) begin
            ost_nxt = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            pend_nxt = 1'b1;
          end
        end else begin
          we = 1'b1;
          addr = ptr_r + idx_r;
          if (idx_r == '0) wdata = tag_r;
          else if (idx_r == CW'(1)) wdata = {5'd0, size_r};
          else wdata = data_r[8*(2'(idx_r[1:0] - 2'd2)) +: 8];
          idx_nxt = idx_r + CW'(1);
          pend_nxt = 1'b1;
          if (idx_r == CW'(size_r) + CW'(1)) begin
            fill_nxt = fill_r + CW'(size_r) + CW'(EntryHead);
            state_nxt = S_DONE;
          end
        end
      end
      S_WALK_TAG: begin
        // issue tag read at ptr, then check it; past the fill it ends as not found
        if (!pend_r) begin
          if (ptr_r >= fill_r) begin
            ost_nxt = ST_NOTFOUND; ptr_nxt = '0;
            state_nxt = S_DONE;
          end else begin
            addr = ptr_r; pend_nxt = 1'b1;
          end
        end else begin
          idx_nxt = (rdata == tag_r) ? CW'(1) : CW'(0);
          addr = ptr_r + CW'(1); pend_nxt = 1'b1;
          state_nxt = S_WALK_LEN;
        end
      end
      S_WALK_LEN: begin
        if (idx_r != '0) begin
          len_nxt = rdata; idx_nxt = '0;
          state_nxt = S_VAL;
        end else begin
          need = (CW+2)'(ptr_r) + (CW+2)'(rdata) + (CW+2)'(EntryHead);
          ptr_nxt = (need >= (CW+2)'(BufferBytes)) ? CW'(BufferBytes) : CW'(need);
          state_nxt = S_WALK_TAG;
        end
      end
      S_VAL: begin
        // read up to four value bytes, one per cycle, then finish or shift for remove
        if (pend_r) begin
          val_nxt = val_r | (32'(rdata) << (8 * (2'(idx_r[1:0] - 2'd1))));
        end
        if (idx_r < CW'(MaxValue) && CW'(idx_r) < CW'(len_r > 8'd4 ? 8'd4 : len_r)
            && (ptr_r + CW'(EntryHead) + idx_r) < CW'(BufferBytes)) begin
          addr = ptr_r + CW'(EntryHead) + idx_r;
          pend_nxt = 1'b1;
          idx_nxt = idx_r + CW'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          if (cmd_r == CMD_REMOVE) begin
            need = (CW+2)'(ptr_r) + (CW+2)'(len_r) + (CW+2)'(EntryHead);
            newfill_nxt = ((CW+2)'(fill_r) > need) ? fill_r - CW'(span) : ptr_r;
            dst_nxt = ptr_r;
            state_nxt = S_SHIFT_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SHIFT_RD: begin
        if (dst_r >= newfill_r) begin
          fill_nxt = newfill_r;
          state_nxt = S_DONE;
        end else begin
          addr = dst_r + span; pend_nxt = 1'b1;
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        we = 1'b1; addr = dst_r; wdata = rdata;
        dst_nxt = dst_r + CW'(1);
        state_nxt = S_SHIFT_RD;
      end
      S_DONE: begin
        // hold result until taken
        if (!ovalid_r) ovalid_nxt = 1'b1;
        else if (out_tready) begin
          ovalid_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
